### hw/rtl/gcpg_pkg.sv
// Shared constants, register codes and the root table of the curve point generator.
`default_nettype none

package gcpg_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int LOG_FRAC      = 24;
  localparam int MANT_W        = 31;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;

  // register codes, word index into the configuration space
  typedef enum logic [2:0] {
    REG_INV_GAMMA,
    REG_BRIGHTNESS,
    REG_CONTRAST,
    REG_BAL_RED,
    REG_BAL_GREEN,
    REG_BAL_BLUE,
    REG_MIN_LEVEL,
    REG_MAX_LEVEL
  } reg_idx_t;

  // pipeline stage positions
  localparam int S_IN    = 0;
  localparam int S_NORM  = 1;
  localparam int S_EXP   = S_NORM + LOG_FRAC + 1;
  localparam int S_SHIFT = S_EXP + LOG_FRAC + 1;
  localparam int S_MULC  = S_SHIFT + 1;
  localparam int S_CURVE = S_MULC + 1;
  localparam int S_MULD  = S_CURVE + 1;
  localparam int S_LEVEL = S_MULD + 1;
  localparam int S_MULG  = S_LEVEL + 1;
  localparam int S_OUT   = S_MULG + 1;
  localparam int NST     = S_OUT + 1;

  typedef logic [31:0] root_tab_t [LOG_FRAC+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] vv;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    vv = v;
    for (int i = 0; i < 32; i++) begin
      if (b > vv) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (vv >= r + b) begin
          vv = vv - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // r[i] = 2^(2^-i) in Q2.30, each one the square root of the one before
  function automatic root_tab_t calc_roots();
    root_tab_t t;
    logic [63:0] w;
    logic [63:0] rt;
    t[0] = 32'h8000_0000;
    for (int i = 1; i <= LOG_FRAC; i++) begin
      w    = {2'b00, t[i-1], 30'b0};
      rt   = isqrt64(w);
      t[i] = rt[31:0];
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gamma_curve_point_generator.sv
// Throughput: one word per cycle while the output is not stalled; log2 takes 24
// squaring stages and 2^f takes 24 root multiply stages, one multiplier each,
// all under one stall enable. A stalled output register holds the whole pipeline.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register
// defaults; datapath registers are not reset.
`default_nettype none

module gamma_curve_point_generator
  import gcpg_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [16:0]       in_position,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [16:0]            out_red_level,
  output logic [16:0]            out_green_level,
  output logic [16:0]            out_blue_level,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int PW   = FRAC_BITS + 5;
  localparam int MCW  = PW + 17;
  localparam int SW   = FRAC_BITS + 23;
  localparam int CW   = FRAC_BITS + 8;
  localparam int CDW  = CW + 18;
  localparam int SHW  = MANT_W + FRAC_BITS;
  localparam int SH0  = 30 - FRAC_BITS;
  localparam logic [SHW-1:0] CAP   = SHW'(1) << (FRAC_BITS + 4);
  localparam logic [PW-1:0]  ONE_P = PW'(1) << FRAC_BITS;
  localparam root_tab_t ROOTS = calc_roots();

  // configuration registers
  logic [15:0] inv_gamma_r, brightness_r, contrast_r;
  logic [15:0] bal_red_r, bal_green_r, bal_blue_r;
  logic [16:0] min_level_r, max_level_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_gamma_r  <= 16'd4096;
      brightness_r <= 16'd16384;
      contrast_r   <= 16'd16384;
      bal_red_r    <= 16'd16384;
      bal_green_r  <= 16'd16384;
      bal_blue_r   <= 16'd16384;
      min_level_r  <= 17'd0;
      max_level_r  <= 17'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INV_GAMMA:  inv_gamma_r  <= cfg_pwdata[15:0];
        REG_BRIGHTNESS: brightness_r <= cfg_pwdata[15:0];
        REG_CONTRAST:   contrast_r   <= cfg_pwdata[15:0];
        REG_BAL_RED:    bal_red_r    <= cfg_pwdata[15:0];
        REG_BAL_GREEN:  bal_green_r  <= cfg_pwdata[15:0];
        REG_BAL_BLUE:   bal_blue_r   <= cfg_pwdata[15:0];
        REG_MIN_LEVEL:  min_level_r  <= cfg_pwdata[16:0];
        REG_MAX_LEVEL:  max_level_r  <= cfg_pwdata[16:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INV_GAMMA:  cfg_prdata = CFG_DW'(inv_gamma_r);
      REG_BRIGHTNESS: cfg_prdata = CFG_DW'(brightness_r);
      REG_CONTRAST:   cfg_prdata = CFG_DW'(contrast_r);
      REG_BAL_RED:    cfg_prdata = CFG_DW'(bal_red_r);
      REG_BAL_GREEN:  cfg_prdata = CFG_DW'(bal_green_r);
      REG_BAL_BLUE:   cfg_prdata = CFG_DW'(bal_blue_r);
      REG_MIN_LEVEL:  cfg_prdata = CFG_DW'(min_level_r);
      REG_MAX_LEVEL:  cfg_prdata = CFG_DW'(max_level_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // pipeline control: one enable, valid bits travel with the words
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv       = !vld_r[S_OUT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[S_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // input register
  logic [16:0] x_r;
  always_ff @(posedge clk) begin
    if (adv) x_r <= in_position;
  end

  // normalise: leading one to bit 30
  logic [4:0]        msb;
  logic [30:0]       m_norm;
  logic [MANT_W-1:0] sq_m_r    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] sq_frac_r [LOG_FRAC+1];
  logic [4:0]        sq_lzc_r  [LOG_FRAC+1];
  logic              sq_zero_r [LOG_FRAC+1];

  always_comb begin
    msb = '0;
    for (int i = 0; i < 17; i++) begin
      if (x_r[i]) msb = 5'(i);
    end
    m_norm = {14'b0, x_r} << (5'd30 - msb);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_m_r[0]    <= m_norm;
      sq_frac_r[0] <= '0;
      sq_lzc_r[0]  <= 5'd16 - msb;
      sq_zero_r[0] <= (x_r == '0);
    end
  end

  // log2 fraction: one squaring per stage
  genvar gi;
  generate
    for (gi = 0; gi < LOG_FRAC; gi++) begin : g_sq
      logic [61:0] sq;
      logic [31:0] t;
      assign sq = {31'b0, sq_m_r[gi]} * {31'b0, sq_m_r[gi]};
      assign t  = sq[61:30];
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_m_r[gi+1]    <= t[31] ? t[31:1] : t[30:0];
          sq_frac_r[gi+1] <= {sq_frac_r[gi][LOG_FRAC-2:0], t[31]};
          sq_lzc_r[gi+1]  <= sq_lzc_r[gi];
          sq_zero_r[gi+1] <= sq_zero_r[gi];
        end
      end
    end
  endgenerate

  // exponent e = floor(log2(x) * g), split into k and f
  logic [5:0]                 nlzc;
  logic signed [29:0]         lg;
  logic signed [46:0]         lgg;
  logic signed [34:0]         ex;
  logic [MANT_W-1:0]          rt_acc_r  [LOG_FRAC+1];
  logic [LOG_FRAC-1:0]        rt_f_r    [LOG_FRAC+1];
  logic signed [10:0]         rt_k_r    [LOG_FRAC+1];
  logic                       rt_zero_r [LOG_FRAC+1];

  assign nlzc = 6'd0 - {1'b0, sq_lzc_r[LOG_FRAC]};
  assign lg   = $signed({nlzc, sq_frac_r[LOG_FRAC]});
  assign lgg  = 47'(lg) * 47'($signed({1'b0, inv_gamma_r}));
  assign ex   = 35'(lgg >>> 12);

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_acc_r[0]  <= 31'h4000_0000;
      rt_f_r[0]    <= ex[LOG_FRAC-1:0];
      rt_k_r[0]    <= ex[34:LOG_FRAC];
      rt_zero_r[0] <= sq_zero_r[LOG_FRAC];
    end
  end

  // 2^f: one conditional root multiply per stage
  generate
    for (gi = 0; gi < LOG_FRAC; gi++) begin : g_rt
      logic [61:0] pr;
      assign pr = {31'b0, rt_acc_r[gi]} * {31'b0, ROOTS[gi+1][30:0]};
      always_ff @(posedge clk) begin
        if (adv) begin
          rt_acc_r[gi+1]  <= rt_f_r[gi][LOG_FRAC-1-gi] ? pr[60:30] : rt_acc_r[gi];
          rt_f_r[gi+1]    <= rt_f_r[gi];
          rt_k_r[gi+1]    <= rt_k_r[gi];
          rt_zero_r[gi+1] <= rt_zero_r[gi];
        end
      end
    end
  endgenerate

  // scale by 2^k and cap at 16.0; a zero inv_gamma gives 1.0, a zero position 0
  logic signed [11:0] rsh;
  logic signed [11:0] lsh;
  logic [SHW-1:0]     wide;
  logic [PW-1:0]      p_nxt;
  logic [PW-1:0]      p_r;

  assign rsh = 12'(SH0) - 12'(rt_k_r[LOG_FRAC]);
  assign lsh = 12'd0 - rsh;

  always_comb begin
    if (rsh >= 0) begin
      if (rsh >= 12'sd31) wide = '0;
      else                wide = SHW'(rt_acc_r[LOG_FRAC] >> rsh[4:0]);
    end else begin
      wide = SHW'(rt_acc_r[LOG_FRAC]) << lsh[4:0];
    end
    priority if (inv_gamma_r == '0)    p_nxt = ONE_P;
    else if (rt_zero_r[LOG_FRAC])      p_nxt = '0;
    else if (wide > CAP)               p_nxt = CAP[PW-1:0];
    else                               p_nxt = wide[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) p_r <= p_nxt;
  end

  // curve value c
  logic [16:0]          cgain;
  logic [MCW-1:0]       mc_r;
  logic signed [16:0]   bdiff;
  logic signed [SW-1:0] s_sum;
  logic signed [CW-1:0] c_r;

  assign cgain = {1'b0, contrast_r} + 17'd16384;

  always_ff @(posedge clk) begin
    if (adv) mc_r <= MCW'(cgain) * MCW'(p_r);
  end

  assign bdiff = $signed({1'b0, brightness_r}) - $signed({1'b0, contrast_r});
  assign s_sum = $signed({1'b0, mc_r}) + (SW'(bdiff) <<< (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (adv) c_r <= CW'(s_sum >>> 15);
  end

  // map onto the level range
  logic signed [17:0]    delta;
  logic signed [CDW-1:0] cd_r;
  logic signed [CDW-1:0] cd_sh;
  logic signed [26:0]    level_r;

  assign delta = $signed({1'b0, max_level_r}) - $signed({1'b0, min_level_r});

  always_ff @(posedge clk) begin
    if (adv) cd_r <= CDW'(c_r) * CDW'(delta);
  end

  assign cd_sh = cd_r >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) level_r <= 27'($signed({1'b0, min_level_r})) + 27'(cd_sh);
  end

  // channel gains
  logic signed [43:0] gr_r, gg_r, gb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      gr_r <= 44'(level_r) * 44'($signed({1'b0, bal_red_r}));
      gg_r <= 44'(level_r) * 44'($signed({1'b0, bal_green_r}));
      gb_r <= 44'(level_r) * 44'($signed({1'b0, bal_blue_r}));
    end
  end

  // saturate: below minimum wins over above maximum
  function automatic logic [16:0] sat(input logic signed [43:0] g,
                                      input logic [16:0] lo,
                                      input logic [16:0] hi);
    logic signed [29:0] v;
    v = 30'(g >>> 14);
    priority if (v < 30'($signed({1'b0, lo}))) return lo;
    else if (v > 30'($signed({1'b0, hi})))     return hi;
    else                                       return v[16:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_red_level   <= sat(gr_r, min_level_r, max_level_r);
      out_green_level <= sat(gg_r, min_level_r, max_level_r);
      out_blue_level  <= sat(gb_r, min_level_r, max_level_r);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/gcpg_checker.sv
// Port-level checker for the curve point generator, bound to the top level.
`default_nettype none

module gcpg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [16:0] out_red_level,
  input wire logic [16:0] out_green_level,
  input wire logic [16:0] out_blue_level
);

  // an empty output register never holds the pipeline
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a word taken at the output frees a slot at the input in the same cycle
  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("input stalled while output drains");

  a_no_word_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_red_level)
      && $stable(out_green_level) && $stable(out_blue_level)))
    else $error("stalled output word changed");

endmodule

bind gamma_curve_point_generator gcpg_checker u_gcpg_checker (.*);

`default_nettype wire

### bench/tb_gamma_curve_point_generator.sv
// Self-checking testbench for the gamma / brightness / contrast curve point generator.
`timescale 1ns / 1ps

module tb_gamma_curve_point_generator;
  import gcpg_pkg::*;

  localparam int FB = 16;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
  } rgb_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [16:0] in_position, out_red_level, out_green_level, out_blue_level;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;

  logic [16:0] pending_pos[$];
  rgb_t levels_due[$];
  longint unsigned curve_reg[8];
  longint unsigned root_tab[LOG_FRAC+1];
  int mismatches = 0;
  int cycle_cnt = 0;
  bit steady = 0;

  gamma_curve_point_generator dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // x^g in Q.FB, clamped at 16.0
  function automatic longint unsigned curve_power(longint unsigned x, longint unsigned g);
    longint unsigned m, acc, frac, f;
    longint lg, e, k, sh;
    int msb;
    if (g == 0) return 64'd1 << FB;
    if (x == 0) return 0;
    msb = 0;
    for (int i = 16; i >= 0; i--)
      if (x[i] && msb == 0) msb = i;
    m = x << (30 - msb);
    frac = 0;
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    lg = longint'(msb - 16) * (64'sd1 <<< LOG_FRAC) + longint'(frac);
    e = (lg * longint'(g)) >>> 12;
    k = e >>> LOG_FRAC;
    f = longint'(e - (k <<< LOG_FRAC));
    acc = 64'd1 << 30;
    for (int i = 1; i <= LOG_FRAC; i++)
      if (f[LOG_FRAC-i]) acc = (acc * root_tab[i]) >> 30;
    sh = (30 - FB) - k;
    if (sh >= 63) acc = 0;
    else if (sh >= 0) acc = acc >> sh;
    else acc = acc << (-sh);
    return (acc > (64'd16 << FB)) ? (64'd16 << FB) : acc;
  endfunction

  function automatic logic [16:0] balance_sat(longint lvl, longint unsigned gain);
    longint v, lo, hi;
    v = (lvl * longint'(gain)) >>> 14;
    lo = longint'(curve_reg[REG_MIN_LEVEL]);
    hi = longint'(curve_reg[REG_MAX_LEVEL]);
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    return v[16:0];
  endfunction

  function automatic rgb_t predict_levels(logic [16:0] pos);
    longint unsigned p;
    longint s, c, lvl;
    rgb_t r;
    p = curve_power(pos, curve_reg[REG_INV_GAMMA]);
    s = longint'((curve_reg[REG_CONTRAST] + 16384) * p)
      + (longint'(curve_reg[REG_BRIGHTNESS]) - longint'(curve_reg[REG_CONTRAST]))
        * (64'sd1 <<< (FB - 1));
    c = s >>> 15;
    lvl = longint'(curve_reg[REG_MIN_LEVEL]) + ((c * (longint'(curve_reg[REG_MAX_LEVEL])
          - longint'(curve_reg[REG_MIN_LEVEL]))) >>> FB);
    r.red = balance_sat(lvl, curve_reg[REG_BAL_RED]);
    r.green = balance_sat(lvl, curve_reg[REG_BAL_GREEN]);
    r.blue = balance_sat(lvl, curve_reg[REG_BAL_BLUE]);
    return r;
  endfunction

  // driver: present the next position, hold it until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) levels_due.push_back(predict_levels(in_position));
      if (!in_valid || in_ready) begin
        if (pending_pos.size() > 0 && (steady || $urandom_range(99) >= 32)) begin
          in_valid <= 1'b1;
          in_position <= pending_pos.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each word with the oldest prediction
  always @(posedge clk) begin
    rgb_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    out_ready <= steady || $urandom_range(99) >= 32;
    if (rst_n && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word r=%0d g=%0d b=%0d",
          out_red_level, out_green_level, out_blue_level);
      end else begin
        want = levels_due.pop_front();
        if (want != {out_red_level, out_green_level, out_blue_level}) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
              want.red, want.green, want.blue,
              out_red_level, out_green_level, out_blue_level);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, longint unsigned val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'(idx) << 2;
    cfg_pwdata <= CFG_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    curve_reg[idx] = (idx >= REG_MIN_LEVEL) ? (val & 64'h1FFFF) : (val & 64'hFFFF);
  endtask

  task automatic set_all(longint unsigned g, longint unsigned br, longint unsigned ct,
                         longint unsigned r, longint unsigned gr, longint unsigned bl,
                         longint unsigned lo, longint unsigned hi);
    write_reg(REG_INV_GAMMA, g);
    write_reg(REG_BRIGHTNESS, br);
    write_reg(REG_CONTRAST, ct);
    write_reg(REG_BAL_RED, r);
    write_reg(REG_BAL_GREEN, gr);
    write_reg(REG_BAL_BLUE, bl);
    write_reg(REG_MIN_LEVEL, lo);
    write_reg(REG_MAX_LEVEL, hi);
  endtask

  // sample away from the rising edge so the driver's updates have settled
  task automatic drain();
    while (pending_pos.size() > 0 || in_valid || levels_due.size() > 0) @(negedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic load_positions(int n);
    logic [16:0] edges[8] = '{17'd0, 17'd1, 17'd2, 17'd32768, 17'd65535, 17'd65536,
                              17'd65537, 17'd131071};
    foreach (edges[i]) pending_pos.push_back(edges[i]);
    for (int i = 0; i < n; i++)
      if ($urandom_range(9) == 0) pending_pos.push_back(17'($urandom_range(131071)));
      else pending_pos.push_back(17'($urandom_range(65536)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_position = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    root_tab[0] = 64'd2 << 30;
    for (int i = 1; i <= LOG_FRAC; i++) root_tab[i] = int_sqrt(root_tab[i-1] << 30);
    curve_reg = '{4096, 16384, 16384, 16384, 16384, 16384, 0, 65536};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults first
    load_positions(130);
    drain();
    set_all(0, 32768, 0, 32768, 0, 16384, 0, 65536);       // zero exponent
    load_positions(60);
    drain();
    set_all(65535, 0, 32768, 0, 32768, 32768, 65536, 0);   // steep curve, min above max
    load_positions(60);
    drain();
    set_all(1, 32768, 32768, 32768, 32768, 32768, 0, 65536);
    load_positions(60);
    drain();
    set_all(4096, 16384, 16384, 16384, 16384, 16384, 100, 200);
    load_positions(60);
    drain();
    steady = 1;
    set_all(2048, 20000, 12000, 20000, 16384, 12000, 3000, 60000);
    load_positions(200);
    drain();
    steady = 0;
    for (int ph = 0; ph < 10; ph++) begin
      set_all($urandom_range(65535), $urandom_range(32768), $urandom_range(32768),
              $urandom_range(32768), $urandom_range(32768), $urandom_range(32768),
              $urandom_range(65536), $urandom_range(65536));
      load_positions(120);
      drain();
    end
    repeat (80) @(posedge clk);
    if (mismatches == 0 && levels_due.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
